### rtl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// I2C target event sequencer package
// Shared types and constants: transfer phases, payload structs and CSR map.
// ----------------------------------------------------------------------------
package i2cts_pkg;

   // Transfer phase; the code doubles as the event kind reported to the app
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WREQ = 3'd1,
      PH_WRCV = 3'd2,
      PH_RREQ = 3'd3,
      PH_RPRC = 3'd4
   } phase_type;

   // Byte sent once the reply data has run out
   localparam logic [7:0] FILL_BYTE = 8'hff;

   // CSR register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIMARY_ADDR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECONDARY_ADDR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE          = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNHANDLED_LIM  = 2'd3;

   localparam logic [7:0] UNHANDLED_LIMIT_RESET = 8'd16;

   // Configuration seen by the sequencer core
   typedef struct packed {
      logic [6:0] primary_address;
      logic [6:0] secondary_address;
      logic       pause_after_stop;
      logic [7:0] unhandled_limit;
   } cfg_type;

   // One status event
   typedef struct packed {
      logic       bus_error;
      logic       ack_error;
      logic       stop_seen;
      logic       rx_full;
      logic       tx_empty;
      logic       addr_match;
      logic       dual_hit;
      logic       master_reads;
      logic [7:0] rx_byte;
      logic [7:0] reply_byte;
      logic       app_refuse;
   } req_type;

   // One result
   typedef struct packed {
      logic       notify;
      logic [2:0] event_kind;
      logic [6:0] matched_address;
      logic [7:0] rx_data;
      logic       tx_load;
      logic [7:0] tx_data;
      logic       ack_enable;
      logic       buffer_irq_on;
      logic       irq_shutdown;
      logic       reset_request;
      logic       handled;
   } rsp_type;

endpackage

### rtl/i2cts_core.sv
// ----------------------------------------------------------------------------
// I2C target event sequencer core
// Holds the transfer state and works through one status event per step.
// ----------------------------------------------------------------------------
module i2cts_core
   import i2cts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   phase_type  phase_ff, phase_in;
   logic       done_ff, done_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       ack_ff, ack_in;
   logic       buf_ff, buf_in;

   phase_type  kind;
   logic       notify;
   logic [7:0] rx_data;
   logic       tx_load;
   logic [7:0] tx_data;
   logic       shutdown;
   logic       reset_req;
   logic       handled;
   logic       write_phase;
   logic       read_phase;

   assign write_phase = (phase_ff == PH_WREQ) || (phase_ff == PH_WRCV);
   assign read_phase  = (phase_ff == PH_RREQ) || (phase_ff == PH_RPRC);

   // State registers, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         addr_ff  <= '0;
         data_ff  <= '0;
         cnt_ff   <= '0;
         ack_ff   <= 1'b1;
         buf_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         cnt_ff   <= cnt_in;
         ack_ff   <= ack_in;
         buf_ff   <= buf_in;
      end
   end

   // Event handling in priority order, then the unhandled-count check
   always_comb begin
      phase_in  = phase_ff;
      done_in   = done_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      ack_in    = ack_ff;
      buf_in    = buf_ff;
      notify    = 1'b0;
      kind      = PH_IDLE;
      rx_data   = '0;
      tx_load   = 1'b0;
      tx_data   = '0;
      shutdown  = 1'b0;
      reset_req = 1'b0;
      handled   = 1'b1;

      if (req.bus_error) begin
         // controller reset
         phase_in  = PH_IDLE;
         ack_in    = 1'b1;
         buf_in    = 1'b0;
         reset_req = 1'b1;
      end else if (req.ack_error || (phase_ff != PH_IDLE && req.stop_seen)) begin
         // end of transfer
         if (!req.ack_error) begin
            ack_in = 1'b1;
         end
         phase_in = PH_IDLE;
         notify   = 1'b1;
         kind     = PH_IDLE;
         buf_in   = 1'b0;
         shutdown = cfg.pause_after_stop;
      end else if (write_phase && req.rx_full) begin
         // byte written by the master
         data_in  = req.rx_byte;
         phase_in = PH_WRCV;
         notify   = 1'b1;
         kind     = PH_WRCV;
         rx_data  = req.rx_byte;
         if (req.app_refuse) begin
            ack_in = 1'b0;
         end
      end else if (read_phase && req.tx_empty) begin
         // master wants the next byte; fill once reply data ran out
         if (!done_ff) begin
            notify = 1'b1;
            kind   = phase_ff;
            if (req.app_refuse) begin
               done_in = 1'b1;
            end else begin
               data_in = req.reply_byte;
            end
         end
         tx_load  = 1'b1;
         tx_data  = done_in ? FILL_BYTE : data_in;
         phase_in = PH_RPRC;
      end else if (req.addr_match) begin
         addr_in = req.dual_hit ? cfg.secondary_address : cfg.primary_address;
         if (req.master_reads) begin
            phase_in = PH_RREQ;
            done_in  = 1'b0;
         end else begin
            phase_in = PH_WREQ;
            notify   = 1'b1;
            kind     = PH_WREQ;
         end
         buf_in = 1'b1;
      end else begin
         handled = 1'b0;
      end

      cnt_in = handled ? 8'd0 : cnt_ff + 8'd1;

      // too many unhandled events: controller reset
      if (cnt_in == cfg.unhandled_limit) begin
         phase_in  = PH_IDLE;
         ack_in    = 1'b1;
         buf_in    = 1'b0;
         cnt_in    = '0;
         reset_req = 1'b1;
      end
   end

   // Result of this step
   always_comb begin
      rsp.notify          = notify;
      rsp.event_kind      = kind;
      rsp.matched_address = addr_in;
      rsp.rx_data         = rx_data;
      rsp.tx_load         = tx_load;
      rsp.tx_data         = tx_data;
      rsp.ack_enable      = ack_in;
      rsp.buffer_irq_on   = buf_in;
      rsp.irq_shutdown    = shutdown;
      rsp.reset_request   = reset_req;
      rsp.handled         = handled;
   end

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.reset_request |=> phase_ff == PH_IDLE && cnt_ff == 8'd0 && ack_ff)
      else $error("reset request did not restore idle state");

   a_unhandled_count: assert property (@(posedge clock) disable iff (reset)
      step_en && !rsp.handled && !rsp.reset_request |=> cnt_ff == $past(cnt_ff) + 8'd1)
      else $error("unhandled count did not advance");

   a_fill_after_done: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.tx_load && done_ff |-> rsp.tx_data == FILL_BYTE && !rsp.notify)
      else $error("reply after end of data was not the fill byte");

endmodule

### rtl/i2c_target_event_sequencer.sv
// ----------------------------------------------------------------------------
// I2C target event sequencer
// Results are registered on rsp_, or in the skid entry while rsp_ is stalled.
// Throughput: one transaction per cycle unless stalled; one-step state update.
// A two-entry output buffer keeps req_ accepting while one result waits.
// Reset: synchronous; idle phase, acknowledge on, buffer irq off, count and
// registers cleared, unhandled limit 16, output buffer empty.
// ----------------------------------------------------------------------------
module i2c_target_event_sequencer
   import i2cts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   rsp_type result;
   logic    push;
   logic    pop;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.primary_address   <= '0;
         cfg_ff.secondary_address <= '0;
         cfg_ff.pause_after_stop  <= 1'b0;
         cfg_ff.unhandled_limit   <= UNHANDLED_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRIMARY_ADDR:   cfg_ff.primary_address   <= csr_wdata[6:0];
            CSR_SECONDARY_ADDR: cfg_ff.secondary_address <= csr_wdata[6:0];
            CSR_PAUSE:          cfg_ff.pause_after_stop  <= csr_wdata[0];
            CSR_UNHANDLED_LIM:  cfg_ff.unhandled_limit   <= csr_wdata[7:0];
         endcase
      end
   end

   assign push = req_valid && !req_stall;
   assign pop  = rsp_valid_ff && !rsp_stall;

   i2cts_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (push),
      .cfg     (cfg_ff),
      .req     (req_data),
      .rsp     (result)
   );

   // Output register plus skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_data_in  = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> rsp_data_ff == $past(skid_data_ff))
      else $error("skid entry lost on drain");

endmodule
